// ===== rtl/spfs_pkg.sv =====
// Shared types and constants for the five-vertex simple path search block.
// Holds field widths, command codes, sequencer states and the result struct.
// No dependencies.
package spfs_pkg;

   localparam int NODE_W = 10;
   localparam int CMD_W = 2;
   localparam int VCOUNT_W = 11;
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_MAX_EDGES = 2048;
   localparam int DEF_PATH_LEN = 5;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_COUNT = 3'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_EDGE = 2'd0,
      CMD_QUERY    = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RA,
      ST_ADD_WA,
      ST_ADD_RB,
      ST_ADD_WB,
      ST_Q_START,
      ST_Q_HEAD,
      ST_Q_STEP,
      ST_Q_SLOT,
      ST_Q_CHECK,
      ST_Q_UNDO,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic valid;
      logic found;
      logic dropped;
   } result_type;

endpackage

// ===== rtl/simple_path_five_search.sv =====
// Top level of the five-vertex simple path search block.
// Instantiates spfs_csr and spfs_engine, holds the response register; uses spfs_pkg.
//
//  Port group   Dir   Contents
//  req_*        in    request: tuser = cmd, tdata = node_a, node_b
//  rsp_*        out   query answer: tdata = found, edges_dropped
//  csr_*        in    register access: vertex_count at byte address 0
//
// An added edge does a head read, then a slot and head write, once for each end of the
// edge. A clear sweeps every vertex entry; the same sweep runs after reset, and requests
// wait meanwhile. A query steps through each adjacency entry visited, each vertex pushed
// and each start vertex, paced by the one shared read port on each memory; a found path
// is then unmarked level by level. A finished answer sits in the response register, so
// new requests are taken while it waits; only a second query's answer waits for
// rsp_tready.
module simple_path_five_search import spfs_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES = DEF_MAX_EDGES,
   parameter int PATH_LEN = DEF_PATH_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [9:0] node_a, [19:10] node_b, rest zero
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] found, [1] edges_dropped, rest zero
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [VCOUNT_W-1:0] vertex_count;
   result_type          result;
   logic                out_free;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_data_ff, rsp_data_in;

   spfs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .vertex_count (vertex_count)
   );

   spfs_engine #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .PATH_LEN     (PATH_LEN)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .vertex_count (vertex_count),
      .req_valid    (req_tvalid),
      .req_cmd      (req_tuser),
      .node_a       (req_tdata[NODE_W-1:0]),
      .node_b       (req_tdata[2*NODE_W-1:NODE_W]),
      .req_ready    (req_tready),
      .out_free     (out_free),
      .result       (result)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {result.dropped, result.found};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'b0, rsp_data_ff};

endmodule

// ===== rtl/spfs_csr.sv =====
// Configuration register file for the path search block (vertex_count).
// Depends on spfs_pkg.
module spfs_csr import spfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [VCOUNT_W-1:0]   vertex_count
);

   logic [VCOUNT_W-1:0] vcount_ff;
   logic [VCOUNT_W-1:0] vcount_in;
   logic                wr_hit;

   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_VERTEX_COUNT);

   always_comb begin
      vcount_in = vcount_ff;
      if (wr_hit) begin
         vcount_in = csr_pwdata[VCOUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_VERTEX_COUNT) begin
         csr_prdata = {{(32-VCOUNT_W){1'b0}}, vcount_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign vertex_count = vcount_ff;

endmodule

// ===== rtl/spfs_engine.sv =====
// Sequencer and graph memories: adjacency lists, on-path marks and search stack.
// Memories with registered reads drive edge loads, clears and the backtracking search.
// Depends on spfs_pkg.
module spfs_engine import spfs_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES = DEF_MAX_EDGES,
   parameter int PATH_LEN = DEF_PATH_LEN
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [VCOUNT_W-1:0] vertex_count,
   input  logic                req_valid,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [NODE_W-1:0]   node_a,
   input  logic [NODE_W-1:0]   node_b,
   output logic                req_ready,
   input  logic                out_free,
   output result_type          result
);

   localparam int SLOT_COUNT = 2 * MAX_EDGES;
   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int SIW = $clog2(SLOT_COUNT);
   localparam int SW = $clog2(SLOT_COUNT + 1);
   localparam int LW = $clog2(PATH_LEN);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W = (CNT_W > VCOUNT_W) ? CNT_W : VCOUNT_W;
   localparam logic [SW-1:0] NIL_SLOT = SW'(SLOT_COUNT);

   // Memories.
   logic [SW-1:0]     head_mem [MAX_VERTICES];
   logic [SW-1:0]     next_mem [SLOT_COUNT];
   logic [NODE_W-1:0] nb_mem   [SLOT_COUNT];
   logic              onp_mem  [MAX_VERTICES];

   logic [VW-1:0]     head_raddr, head_waddr, onp_raddr, onp_waddr;
   logic [SW-1:0]     head_wdata;
   logic              head_we, onp_we, onp_wdata;
   logic [SIW-1:0]    slot_raddr, slot_waddr;
   logic [SW-1:0]     slot_wnext;
   logic [NODE_W-1:0] slot_wnb;
   logic              slot_we;
   logic [SW-1:0]     head_rd_ff, next_rd_ff;
   logic [NODE_W-1:0] nb_rd_ff;
   logic              onp_rd_ff;

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         next_mem[slot_waddr] <= slot_wnext;
         nb_mem[slot_waddr] <= slot_wnb;
      end
      next_rd_ff <= next_mem[slot_raddr];
      nb_rd_ff <= nb_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (onp_we) begin
         onp_mem[onp_waddr] <= onp_wdata;
      end
      onp_rd_ff <= onp_mem[onp_raddr];
   end

   // Control and search stack.
   state_type         state_ff, state_in;
   logic [VW-1:0]     clr_idx_ff, clr_idx_in;
   logic [SW-1:0]     slots_ff, slots_in;
   logic              drop_ff, drop_in;
   logic              found_ff, found_in;
   logic [LW-1:0]     level_ff, level_in;
   logic [VW-1:0]     start_ff, start_in;
   logic [VW-1:0]     node_a_ff, node_a_in, node_b_ff, node_b_in;
   logic [VW-1:0]     w_ff, w_in;
   logic              w_ok_ff, w_ok_in;
   logic [VW-1:0]     vert_ff [PATH_LEN];
   logic [SW-1:0]     cur_ff  [PATH_LEN];
   logic              vert_we, cur_we;
   logic [LW-1:0]     stk_idx;
   logic [VW-1:0]     vert_wdata;
   logic [SW-1:0]     cur_wdata;

   logic [CMP_W-1:0]  live_n;
   logic              edge_bad;
   logic [LW-1:0]     level_up;

   always_comb begin
      if (CMP_W'(vertex_count) > CMP_W'(MAX_VERTICES)) begin
         live_n = CMP_W'(MAX_VERTICES);
      end else begin
         live_n = CMP_W'(vertex_count);
      end
   end

   assign edge_bad = (CMP_W'(node_a) >= live_n) || (CMP_W'(node_b) >= live_n)
                     || (({1'b0, slots_ff} + (SW+1)'(2)) > (SW+1)'(SLOT_COUNT));
   assign level_up = level_ff + LW'(1);

   always_comb begin
      state_in = state_ff;
      clr_idx_in = clr_idx_ff;
      slots_in = slots_ff;
      drop_in = drop_ff;
      found_in = found_ff;
      level_in = level_ff;
      start_in = start_ff;
      node_a_in = node_a_ff;
      node_b_in = node_b_ff;
      w_in = w_ff;
      w_ok_in = w_ok_ff;
      head_raddr = '0;
      head_waddr = '0;
      head_wdata = NIL_SLOT;
      head_we = 1'b0;
      slot_raddr = '0;
      slot_waddr = slots_ff[SIW-1:0];
      slot_wnext = head_rd_ff;
      slot_wnb = '0;
      slot_we = 1'b0;
      onp_raddr = '0;
      onp_waddr = '0;
      onp_wdata = 1'b0;
      onp_we = 1'b0;
      vert_we = 1'b0;
      cur_we = 1'b0;
      stk_idx = level_ff;
      vert_wdata = '0;
      cur_wdata = head_rd_ff;
      req_ready = 1'b0;
      result = '0;

      case (state_ff)
         ST_CLEAR: begin
            head_waddr = clr_idx_ff;
            head_we = 1'b1;
            onp_waddr = clr_idx_ff;
            onp_we = 1'b1;
            clr_idx_in = clr_idx_ff + VW'(1);
            if (clr_idx_ff == VW'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            node_a_in = VW'(node_a);
            node_b_in = VW'(node_b);
            if (req_valid) begin
               case (req_cmd)
                  CMD_ADD_EDGE: begin
                     if (edge_bad) begin
                        drop_in = 1'b1;
                     end else begin
                        state_in = ST_ADD_RA;
                     end
                  end
                  CMD_QUERY: begin
                     found_in = 1'b0;
                     start_in = '0;
                     if (live_n == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_Q_START;
                     end
                  end
                  CMD_CLEAR: begin
                     slots_in = '0;
                     drop_in = 1'b0;
                     clr_idx_in = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_RA: begin
            head_raddr = node_a_ff;
            state_in = ST_ADD_WA;
         end
         ST_ADD_WA: begin
            slot_wnb = NODE_W'(node_b_ff);
            slot_we = 1'b1;
            head_waddr = node_a_ff;
            head_wdata = slots_ff;
            head_we = 1'b1;
            slots_in = slots_ff + SW'(1);
            state_in = ST_ADD_RB;
         end
         ST_ADD_RB: begin
            head_raddr = node_b_ff;
            state_in = ST_ADD_WB;
         end
         ST_ADD_WB: begin
            slot_wnb = NODE_W'(node_a_ff);
            slot_we = 1'b1;
            head_waddr = node_b_ff;
            head_wdata = slots_ff;
            head_we = 1'b1;
            slots_in = slots_ff + SW'(1);
            state_in = ST_IDLE;
         end
         ST_Q_START: begin
            level_in = '0;
            stk_idx = '0;
            vert_wdata = start_ff;
            vert_we = 1'b1;
            onp_waddr = start_ff;
            onp_wdata = 1'b1;
            onp_we = 1'b1;
            head_raddr = start_ff;
            state_in = ST_Q_HEAD;
         end
         ST_Q_HEAD: begin
            cur_we = 1'b1;
            state_in = ST_Q_STEP;
         end
         ST_Q_STEP: begin
            if (level_ff == LW'(PATH_LEN - 1)) begin
               found_in = 1'b1;
               state_in = ST_Q_UNDO;
            end else if (cur_ff[level_ff] >= NIL_SLOT) begin
               // List exhausted: unmark this vertex; back up or take the next start.
               onp_waddr = vert_ff[level_ff];
               onp_we = 1'b1;
               if (level_ff == '0) begin
                  if ((CMP_W'(start_ff) + CMP_W'(1)) >= live_n) begin
                     state_in = ST_DONE;
                  end else begin
                     start_in = start_ff + VW'(1);
                     state_in = ST_Q_START;
                  end
               end else begin
                  level_in = level_ff - LW'(1);
               end
            end else begin
               slot_raddr = cur_ff[level_ff][SIW-1:0];
               state_in = ST_Q_SLOT;
            end
         end
         ST_Q_SLOT: begin
            cur_wdata = next_rd_ff;
            cur_we = 1'b1;
            w_in = VW'(nb_rd_ff);
            w_ok_in = ({1'b0, nb_rd_ff} < (NODE_W+1)'(MAX_VERTICES > 2047 ? 2047 : MAX_VERTICES))
                      || (MAX_VERTICES > 1024);
            onp_raddr = VW'(nb_rd_ff);
            state_in = ST_Q_CHECK;
         end
         ST_Q_CHECK: begin
            if (w_ok_ff && !onp_rd_ff) begin
               level_in = level_up;
               stk_idx = level_up;
               vert_wdata = w_ff;
               vert_we = 1'b1;
               onp_waddr = w_ff;
               onp_wdata = 1'b1;
               onp_we = 1'b1;
               head_raddr = w_ff;
               state_in = ST_Q_HEAD;
            end else begin
               state_in = ST_Q_STEP;
            end
         end
         ST_Q_UNDO: begin
            onp_waddr = vert_ff[level_ff];
            onp_we = 1'b1;
            if (level_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               level_in = level_ff - LW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               result.valid = 1'b1;
               result.found = found_ff;
               result.dropped = drop_ff;
               level_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_idx_ff <= '0;
         slots_ff <= '0;
         drop_ff <= 1'b0;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_idx_ff <= clr_idx_in;
         slots_ff <= slots_in;
         drop_ff <= drop_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      start_ff <= start_in;
      node_a_ff <= node_a_in;
      node_b_ff <= node_b_in;
      w_ff <= w_in;
      w_ok_ff <= w_ok_in;
      if (vert_we) begin
         vert_ff[stk_idx] <= vert_wdata;
      end
      if (cur_we) begin
         cur_ff[stk_idx] <= cur_wdata;
      end
   end

endmodule
